// File: rtl/mmp_pkg.sv
// Shared types and constants of the masked mean pooling block.
`timescale 1ns / 1ps
package mmp_pkg;
  localparam int unsigned EmbedWidthDef = 384;
  localparam int unsigned MaxTokensDef  = 128;
  localparam int unsigned SumW   = 40;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    KIND_NOTICE = 1'b0,
    KIND_DATA   = 1'b1
  } kind_e;

  typedef struct packed {
    logic        is_read;
    logic [31:0] value;
    logic        tok;
    logic        last;
    logic [8:0]  index;
  } req_t;
endpackage

// File: rtl/mmp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module mmp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/mmp_front.sv
// Request queue between the input channel and the pooling engine.
`timescale 1ns / 1ps
module mmp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mmp_pkg::req_t in_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output mmp_pkg::req_t q_req_o
);
  import mmp_pkg::*;
  req_t       buf_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 3'd4);
  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 3'd0);
  assign q_req_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// File: rtl/mmp_back.sv
// Pooling engine: accumulation, finalize walk with divider and square root, reads.
`timescale 1ns / 1ps
module mmp_back #(
  parameter int unsigned EmbedWidth = mmp_pkg::EmbedWidthDef,
  parameter int unsigned MaxTokens  = mmp_pkg::MaxTokensDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  mmp_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          result_kind_o,
  output logic [15:0]   result_value_o,
  output logic [7:0]    valid_tokens_o
);
  import mmp_pkg::*;
  localparam int unsigned AW = (EmbedWidth > 1) ? $clog2(EmbedWidth) : 1;
  localparam int unsigned TW = $clog2(MaxTokens + 1);
  localparam logic [AW-1:0] LastIdx = AW'(EmbedWidth - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ACC   = 11'b00000000010, // read-modify-write of one sum
    S_RDWT  = 11'b00000000100, // read data wait
    S_MREAD = 11'b00000001000, // pass 1: read sum
    S_MDIV  = 11'b00000010000, // pass 1: divide by count, square, add
    S_SQRT  = 11'b00000100000,
    S_NREAD = 11'b00001000000, // pass 2: read sum again
    S_NDIV1 = 11'b00010000000, // pass 2: mean by count
    S_NDIV2 = 11'b00100000000, // pass 2: scaled mean by norm
    S_OUT   = 11'b01000000000,
    S_CLR   = 11'b10000000000  // zero fill of the sums and, if asked, the results
  } state_e;

  state_e       st_q;
  logic [AW-1:0] elem_q;
  logic [TW-1:0] row_q;
  logic [7:0]   vcnt_q;
  logic [AW-1:0] wi_q;
  logic         pend_tok_q;
  logic [31:0]  pend_x_q;
  logic [AW-1:0] pend_a_q;
  logic         rd_oor_q;
  logic         pend_tok_q_last;
  logic [AW-1:0] p_ra_q;
  logic         clr_pool_q, clr_to_out_q;

  // S_MREAD/S_NREAD need registered read data in the cycle after the address.
  logic rd_ready_q;

  // memories
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [SumW-1:0] s_wd, s_rd;
  logic          p_we;
  logic [AW-1:0] p_wa, p_ra;
  logic [15:0]   p_wd, p_rd;

  mmp_ram #(.Width(SumW), .Depth(EmbedWidth)) u_sums (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  mmp_ram #(.Width(16), .Depth(EmbedWidth)) u_pool (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));

  // output register
  logic        ov_q, okind_q;
  logic [15:0] oval_q;
  logic [7:0]  otok_q;
  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign result_value_o = oval_q;
  assign valid_tokens_o = otok_q;
  logic o_free;
  assign o_free = !ov_q || !out_stall_i;

  // Shared restoring divider: 72-bit magnitude by 40-bit magnitude, 1 bit a cycle.
  logic [71:0] dv_n_q, dv_q_q;
  logic [39:0] dv_d_q;
  logic [40:0] dv_r_q;
  logic [6:0]  dv_cnt_q;
  logic        dv_neg_q, dv_busy_q, dv_go;
  logic [71:0] dv_go_n;
  logic [39:0] dv_go_d;
  logic        dv_go_neg;
  logic [40:0] dv_sh;
  assign dv_sh = {dv_r_q[39:0], dv_n_q[71]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0; dv_cnt_q <= '0;
    end else if (dv_go) begin
      dv_busy_q <= 1'b1; dv_cnt_q <= 7'd72;
    end else if (dv_busy_q) begin
      dv_cnt_q <= dv_cnt_q - 7'd1;
      if (dv_cnt_q == 7'd1) dv_busy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (dv_go) begin
      dv_n_q <= dv_go_n; dv_d_q <= dv_go_d; dv_neg_q <= dv_go_neg;
      dv_r_q <= '0; dv_q_q <= '0;
    end else if (dv_busy_q) begin
      dv_n_q <= {dv_n_q[70:0], 1'b0};
      if (dv_sh >= {1'b0, dv_d_q}) begin
        dv_r_q <= dv_sh - {1'b0, dv_d_q};
        dv_q_q <= {dv_q_q[70:0], 1'b1};
      end else begin
        dv_r_q <= dv_sh;
        dv_q_q <= {dv_q_q[70:0], 1'b0};
      end
    end
  end
  logic dv_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_done_q <= 1'b0;
    else dv_done_q <= dv_busy_q && (dv_cnt_q == 7'd1);
  end

  // Divider result with sign, clamped to 32 bits and to 16 bits.
  logic [31:0] mean_c;
  logic [15:0] q16_c;
  always_comb begin
    if (!dv_neg_q) begin
      mean_c = (dv_q_q > 72'h7FFFFFFF) ? 32'h7FFFFFFF : dv_q_q[31:0];
      q16_c  = (dv_q_q > 72'd32767) ? 16'h7FFF : dv_q_q[15:0];
    end else begin
      mean_c = (dv_q_q > 72'h80000000) ? 32'h80000000 : 32'(-dv_q_q[32:0]);
      q16_c  = (dv_q_q > 72'd32768) ? 16'h8000 : 16'(-dv_q_q[16:0]);
    end
  end

  // Square and sum of squares; the multiplier output is registered.
  logic [63:0] sq_q;
  logic        sq_v_q;
  logic [75:0] ssum_q;
  logic [31:0] mean_abs;
  assign mean_abs = mean_c[31] ? 32'(-mean_c) : mean_c;

  // Square root, one result bit per cycle once the last square is in the sum: restoring digit-by-digit.
  logic [75:0] rt_x_q;
  logic [77:0] rt_r_q;
  logic [37:0] rt_root_q;
  logic [5:0]  rt_cnt_q;
  logic [77:0] rt_rs, rt_t;
  assign rt_rs = {rt_r_q[75:0], rt_x_q[75:74]};
  assign rt_t  = {38'b0, rt_root_q, 2'b01};

  logic [7:0] cnt_for_div;
  assign cnt_for_div = vcnt_q;
  logic [39:0] sum_val;
  assign sum_val = s_rd;

  // accumulation arithmetic
  logic [40:0] acc_sum;
  logic [39:0] acc_sat, acc_old;
  assign acc_old = s_rd;
  assign acc_sum = {acc_old[39], acc_old} + {{9{pend_x_q[31]}}, pend_x_q};
  always_comb begin
    if (acc_sum[40] != acc_sum[39])
      acc_sat = acc_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    else acc_sat = acc_sum[39:0];
  end

  logic in_row, take;
  assign in_row  = (row_q < TW'(MaxTokens));
  assign take    = (st_q == S_IDLE) && q_valid_i &&
                   (q_req_i.is_read == REQ_READ || !q_req_i.last || o_free);
  assign q_pop_o = take;

  always_comb begin
    s_we = 1'b0; s_wa = pend_a_q; s_wd = acc_sat; s_ra = AW'(q_req_i.index);
    p_we = 1'b0; p_wa = wi_q; p_wd = q16_c; p_ra = AW'(q_req_i.index);
    dv_go = 1'b0; dv_go_n = '0; dv_go_d = '0; dv_go_neg = 1'b0;
    case (st_q)
      S_ACC: s_we = pend_tok_q;
      S_RDWT: p_ra = p_ra_q;
      S_MREAD, S_NREAD: s_ra = wi_q;
      S_CLR: begin
        s_we = 1'b1; s_wa = wi_q; s_wd = '0;
        p_we = clr_pool_q; p_wd = '0;
      end
      default: ;
    endcase
    if (st_q == S_IDLE && take && q_req_i.is_read == REQ_PUSH)
      s_ra = elem_q;
    if (st_q == S_NDIV2 && dv_done_q) p_we = 1'b1;
    // Launch the divider once the sum read data is valid.
    if ((st_q == S_MREAD || st_q == S_NREAD) && rd_ready_q) begin
      dv_go = 1'b1;
      dv_go_neg = sum_val[39];
      dv_go_n = {32'b0, (sum_val[39] ? 40'(-sum_val) : sum_val)};
      dv_go_d = {32'b0, cnt_for_div};
    end
    if (st_q == S_NDIV1 && dv_done_q) begin
      dv_go = 1'b1;
      dv_go_neg = mean_c[31];
      dv_go_n = {25'b0, mean_abs, 15'b0};
      dv_go_d = {2'b0, rt_root_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; elem_q <= '0; row_q <= '0; vcnt_q <= '0; wi_q <= '0;
      ov_q <= 1'b0; sq_v_q <= 1'b0; ssum_q <= '0;
      rt_cnt_q <= '0; rd_ready_q <= 1'b0;
      clr_pool_q <= 1'b1; clr_to_out_q <= 1'b0;
      okind_q <= KIND_NOTICE; oval_q <= '0; otok_q <= '0;
    end else begin
      sq_v_q <= (st_q == S_MDIV) && dv_done_q;
      if (sq_v_q) ssum_q <= ssum_q + {12'b0, sq_q};
      case (st_q)
        S_IDLE: if (take) begin
          if (q_req_i.is_read == REQ_READ) st_q <= S_RDWT;
          else begin
            if (elem_q == '0 && row_q == '0) vcnt_q <= (q_req_i.tok) ? 8'd1 : 8'd0;
            else if (in_row && elem_q == '0 && q_req_i.tok && vcnt_q != 8'hFF)
              vcnt_q <= vcnt_q + 8'd1;
            if (elem_q == LastIdx) begin
              elem_q <= '0;
              if (row_q < TW'(MaxTokens)) row_q <= row_q + TW'(1);
            end else elem_q <= elem_q + AW'(1);
            st_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (!pend_tok_q_last) st_q <= S_IDLE;
          else begin
            wi_q <= '0; ssum_q <= '0; rd_ready_q <= 1'b0;
            if (vcnt_q == 8'd0) begin
              st_q <= S_CLR; clr_pool_q <= 1'b1; clr_to_out_q <= 1'b1;
            end else st_q <= S_MREAD;
          end
        end
        S_RDWT: if (o_free) st_q <= S_IDLE;
        S_MREAD: begin
          if (rd_ready_q) begin
            rd_ready_q <= 1'b0; st_q <= S_MDIV;
          end else rd_ready_q <= 1'b1;
        end
        S_MDIV: if (dv_done_q) begin
          if (wi_q == LastIdx) begin
            wi_q <= '0; st_q <= S_SQRT; rt_cnt_q <= 6'd39;
          end else begin
            wi_q <= wi_q + AW'(1); st_q <= S_MREAD;
          end
        end
        S_SQRT: if (!sq_v_q) begin
          if (rt_cnt_q == 6'd0) begin
            if (rt_root_q == '0) begin
              st_q <= S_CLR; clr_pool_q <= 1'b1; clr_to_out_q <= 1'b1;
            end else st_q <= S_NREAD;
          end else rt_cnt_q <= rt_cnt_q - 6'd1;
        end
        S_NREAD: begin
          if (rd_ready_q) begin
            rd_ready_q <= 1'b0; st_q <= S_NDIV1;
          end else rd_ready_q <= 1'b1;
        end
        S_NDIV1: if (dv_done_q) st_q <= S_NDIV2;
        S_NDIV2: if (dv_done_q) begin
          if (wi_q == LastIdx) begin
            wi_q <= '0; st_q <= S_CLR; clr_pool_q <= 1'b0; clr_to_out_q <= 1'b1;
          end else begin wi_q <= wi_q + AW'(1); st_q <= S_NREAD; end
        end
        S_CLR: begin
          if (wi_q == LastIdx) begin
            wi_q <= '0;
            st_q <= clr_to_out_q ? S_OUT : S_IDLE;
          end else wi_q <= wi_q + AW'(1);
        end
        S_OUT: begin
          elem_q <= '0; row_q <= '0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
      if (st_q == S_RDWT && o_free) begin
        ov_q <= 1'b1; okind_q <= KIND_DATA;
        oval_q <= rd_oor_q ? 16'd0 : p_rd;
        otok_q <= vcnt_q;
      end else if (st_q == S_OUT) begin
        ov_q <= 1'b1; okind_q <= KIND_NOTICE; oval_q <= '0; otok_q <= vcnt_q;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_tok_q <= q_req_i.tok && in_row && (q_req_i.is_read == REQ_PUSH);
      pend_x_q   <= q_req_i.value;
      pend_a_q   <= elem_q;
      pend_tok_q_last <= q_req_i.last;
      rd_oor_q   <= ({23'b0, q_req_i.index} >= 32'(EmbedWidth));
      p_ra_q     <= AW'(q_req_i.index);
    end
    if (st_q == S_MDIV && dv_done_q) begin
      sq_q <= 64'(mean_abs) * 64'(mean_abs);
    end
    if (st_q == S_MDIV && dv_done_q && wi_q == LastIdx) begin
      rt_x_q <= '0; rt_r_q <= '0; rt_root_q <= '0;
    end else if (st_q == S_SQRT && !sq_v_q && rt_cnt_q != 6'd0) begin
      if (rt_cnt_q == 6'd39) rt_x_q <= ssum_q;
      if (rt_cnt_q != 6'd39) begin
        rt_x_q <= {rt_x_q[73:0], 2'b00};
        if (rt_rs >= rt_t) begin
          rt_r_q <= rt_rs - rt_t; rt_root_q <= {rt_root_q[36:0], 1'b1};
        end else begin
          rt_r_q <= rt_rs; rt_root_q <= {rt_root_q[36:0], 1'b0};
        end
      end
    end
  end
endmodule

// File: rtl/masked_mean_pool_l2_normalize.sv
// Top level of the masked mean pooling and L2 normalization block.
`timescale 1ns / 1ps
// Usage: requests enter on in_valid_i/in_stall_o; a push adds one Q16.16
// element of a token-major matrix, a read returns one stored Q1.15 component.
// Results leave on out_valid_o/out_stall_i from an output register: one
// data result per read and one notice per push marked last_element.
// A four-entry request queue decouples the input from the engine.
// A push takes two steps in the engine (sum read, then write back); a read
// passes the pool read and a wait state, then the output register. The last
// element starts a finalize walk: a mean pass (per component: read the sum,
// divide by the token count, add the square), the square root, a scaling
// pass (read, divide by count, divide by the norm, store) and a pass that
// clears the sums; both passes share one divider. With no valid token the
// walk is only the clearing pass. No request is taken during the walk.
// Reset starts a clearing pass that zeroes both stores; requests wait in
// the queue until it ends. A stalled receiver holds the result register;
// at a read or last push the engine waits and the full queue raises in_stall_o.
module masked_mean_pool_l2_normalize #(
  parameter int unsigned EmbedWidth = mmp_pkg::EmbedWidthDef,
  parameter int unsigned MaxTokens  = mmp_pkg::MaxTokensDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] hidden_value_i,
  input  logic        token_valid_i,
  input  logic        last_element_i,
  input  logic [8:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [15:0] result_value_o,
  output logic [7:0]  valid_tokens_o
);
  import mmp_pkg::*;
  req_t in_req, q_req;
  logic q_valid, q_pop;
  assign in_req = '{is_read: req_type_i, value: hidden_value_i, tok: token_valid_i,
                    last: last_element_i, index: read_index_i};

  mmp_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req));

  mmp_back #(.EmbedWidth(EmbedWidth), .MaxTokens(MaxTokens)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o, .out_stall_i, .result_kind_o, .result_value_o, .valid_tokens_o);
endmodule

// File: bench/masked_mean_pool_l2_normalize_checker.sv
// Checker for the masked mean pooling block: predicts and compares results.
`timescale 1ns / 1ps
module masked_mean_pool_l2_normalize_checker
  import mmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        req_type_i,
  input  logic [31:0] hidden_value_i,
  input  logic        token_valid_i,
  input  logic        last_element_i,
  input  logic [8:0]  read_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        result_kind_i,
  input  logic [15:0] result_value_i,
  input  logic [7:0]  valid_tokens_i,
  output int          errors_o,
  output int          pending_o
);
  localparam int unsigned Dim = EmbedWidthDef;
  localparam int unsigned Rows = MaxTokensDef;
  localparam longint SumHi = 64'sd549755813887;
  localparam longint SumLo = -64'sd549755813888;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [7:0]  tokens;
  } pooled_result_t;

  longint         dim_acc [Dim];
  shortint        unit_vec [Dim];
  longint         mean_vec [Dim];
  int unsigned    col_pos;
  int unsigned    row_pos;
  int unsigned    tok_count;
  pooled_result_t awaited_q [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors_o++;
  endtask

  // Mean per dimension, then scale to unit length.
  function automatic void pool_and_normalize();
    logic [127:0] sq_total;
    logic [127:0] trial;
    longint       m;
    longint       norm;
    longint       q;
    sq_total = '0;
    norm = 0;
    for (int i = 0; i < Dim; i++) unit_vec[i] = 0;
    if (tok_count > 0) begin
      for (int i = 0; i < Dim; i++) begin
        m = dim_acc[i] / longint'(tok_count);
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        mean_vec[i] = m;
        sq_total += 128'(m * m);
      end
      for (int b = 37; b >= 0; b--) begin
        trial = 128'(norm) | (128'd1 << b);
        if (trial * trial <= sq_total) norm = longint'(trial);
      end
      if (norm > 0) begin
        for (int i = 0; i < Dim; i++) begin
          q = (mean_vec[i] * 32768) / norm;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          unit_vec[i] = shortint'(q);
        end
      end
    end
    for (int i = 0; i < Dim; i++) dim_acc[i] = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void absorb_element(input logic [31:0] raw, input logic tok,
                                         input logic last);
    longint s;
    if (col_pos == 0 && row_pos == 0) tok_count = 0;
    if (row_pos < Rows && col_pos < Dim) begin
      if (col_pos == 0 && tok && tok_count < 255) tok_count++;
      if (tok) begin
        s = dim_acc[col_pos] + longint'(signed'(raw));
        if (s > SumHi) s = SumHi;
        if (s < SumLo) s = SumLo;
        dim_acc[col_pos] = s;
      end
    end
    col_pos++;
    if (col_pos >= Dim) begin
      col_pos = 0;
      if (row_pos < Rows) row_pos++;
    end
    if (last) begin
      pool_and_normalize();
      awaited_q.push_back('{KIND_NOTICE, 16'd0, 8'(tok_count)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < Dim; i++) begin
        dim_acc[i] = 0;
        unit_vec[i] = 0;
      end
      col_pos = 0;
      row_pos = 0;
      tok_count = 0;
      awaited_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (req_e'(req_type_i) == REQ_READ) begin
          awaited_q.push_back('{KIND_DATA,
              (read_index_i < Dim) ? 16'(unit_vec[read_index_i]) : 16'd0,
              8'(tok_count)});
        end else begin
          absorb_element(hidden_value_i, token_valid_i, last_element_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_r = awaited_q.pop_front();
          if (result_kind_i != exp_r.kind)
            report($sformatf("kind %0d, expected %0d", result_kind_i, exp_r.kind));
          if (result_value_i != exp_r.value)
            report($sformatf("value %0d, expected %0d",
                             $signed(result_value_i), $signed(exp_r.value)));
          if (valid_tokens_i != exp_r.tokens)
            report($sformatf("tokens %0d, expected %0d", valid_tokens_i, exp_r.tokens));
        end
      end
      pending_o = awaited_q.size();
    end
  end
endmodule

// File: bench/masked_mean_pool_l2_normalize_tb.sv
// Testbench top for the masked mean pooling block: stimulus and verdict.
`timescale 1ns / 1ps
module masked_mean_pool_l2_normalize_tb;
  import mmp_pkg::*;

  localparam int unsigned Dim = EmbedWidthDef;
  localparam int IdleLimit = 500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = REQ_PUSH;
  logic [31:0] hidden_value_i = '0;
  logic        token_valid_i = 1'b0;
  logic        last_element_i = 1'b0;
  logic [8:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [15:0] result_value_o;
  logic [7:0]  valid_tokens_o;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit long_hold = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  masked_mean_pool_l2_normalize dut (.*);

  masked_mean_pool_l2_normalize_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i,
    .hidden_value_i, .token_valid_i, .last_element_i, .read_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_kind_i(result_kind_o),
    .result_value_i(result_value_o), .valid_tokens_i(valid_tokens_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random hold before each result, plus one long hold on request.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      w = recv_gaps ? $urandom_range(0, 9) : 0;
      repeat (w) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("masked_mean_pool_l2_normalize_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_request(input req_e kind, input logic [31:0] value,
                              input logic tok, input logic last, input logic [8:0] idx);
    int gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    hidden_value_i <= value;
    token_valid_i <= tok;
    last_element_i <= last;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_element(input logic [31:0] value, input logic tok, input logic last);
    send_request(REQ_PUSH, value, tok, last, 9'($urandom));
  endtask

  task automatic read_component(input logic [8:0] idx);
    send_request(REQ_READ, $urandom, 1'($urandom), 1'($urandom), idx);
  endtask

  // The sender pauses until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n_len;
    logic row_tok;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reads after reset see an empty vector and a zero count.
    read_component(9'd0);
    read_component(9'(Dim - 1));
    read_component(9'(Dim));
    read_component(9'd511);

    // Short sequence with extreme values that ends early in its row.
    push_element(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_element(32'h8000_0000, 1'b1, 1'b0);
    push_element(32'h0001_0000, 1'b1, 1'b1);
    read_component(9'd0);
    read_component(9'd1);
    read_component(9'd2);
    read_component(9'(Dim - 1));
    drain_results();

    // Zero norm: one valid token whose elements are all zero.
    push_element(32'd0, 1'b1, 1'b0);
    push_element(32'd0, 1'b1, 1'b1);
    read_component(9'd0);
    drain_results();

    // No valid token at all.
    push_element(32'd5, 1'b0, 1'b0);
    push_element(32'd7, 1'b0, 1'b1);
    read_component(9'd1);
    drain_results();

    // Fill the block while the receiver holds off.
    long_hold = 1'b1;
    for (int k = 0; k < 20; k++) read_component(9'($urandom_range(0, Dim - 1)));
    drain_results();

    // Random sequences, mostly well formed, with reads mixed in; the last
    // one runs past the end of its first row.
    for (int s = 0; s < 5; s++) begin
      send_gaps = (s != 2);
      recv_gaps = (s != 3);
      for (int k = $urandom_range(5, 15); k > 0; k--)
        read_component(($urandom_range(0, 7) == 0) ? 9'($urandom)
                                                   : 9'($urandom_range(0, Dim - 1)));
      n_len = (s == 4) ? $urandom_range(Dim + 1, Dim + 8) : $urandom_range(5, 20);
      row_tok = 1'($urandom);
      for (int e = 0; e < n_len; e++) begin
        if (e % Dim == 0) row_tok = ($urandom_range(0, 3) != 0);
        // Now and then the mask changes inside a row.
        if ($urandom_range(0, 15) == 0) row_tok = !row_tok;
        if ($urandom_range(0, 31) == 0) read_component(9'($urandom));
        push_element(pick_value(), row_tok, e == n_len - 1);
      end
      for (int k = 0; k < 8; k++) read_component(9'($urandom_range(0, Dim - 1)));
      drain_results();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("masked_mean_pool_l2_normalize_tb: clean");
    end else begin
      $display("masked_mean_pool_l2_normalize_tb: errors");
    end
    $finish;
  end
endmodule
